### rtl/bdpe_pkg.sv
// ----------------------------------------------------------------------------
// bdpe_pkg
// Shared types, widths and constants for the bucket dedup / priority emitter.
// ----------------------------------------------------------------------------
package bdpe_pkg;

    localparam int TABLE_SLOTS_DEF = 4096;
    localparam int MAX_RESULTS_DEF = 1024;
    localparam int QUEUE_DEPTH     = 2;

    localparam int COORD_W  = 16;
    localparam int KEY_W    = 3 * COORD_W;
    localparam int ENTRY_W  = KEY_W + 1;
    localparam int ZOOM_W   = 5;
    localparam int WEIGHT_W = 21;
    localparam int PRIO_W   = 22;
    localparam int DIST_W   = 18;
    localparam int IDX_W    = 10;
    localparam int LIMIT_W  = 12;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 88;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    // splitmix64 finalizer constants
    localparam logic [63:0] HASH_INC  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] HASH_MUL1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] HASH_MUL2 = 64'h94D0_49BB_1331_11EB;
    localparam int          HASH_SH1  = 30;
    localparam int          HASH_SH2  = 27;
    localparam int          HASH_SH3  = 31;

    typedef enum logic [2:0] {
        ST_DUPLICATE   = 3'd0,
        ST_ACCEPTED    = 3'd1,
        ST_ACCEPT_STOP = 3'd2,
        ST_OUT_FULL    = 3'd3,
        ST_TABLE_FULL  = 3'd4,
        ST_CLEARED     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CENTER_Z    = 3'd2,
        REG_WEIGHT      = 3'd3,
        REG_ZOOM        = 3'd4,
        REG_ABORT_LIMIT = 3'd5
    } reg_idx_t;

    typedef enum logic {
        FUNC_CLEAR = 1'b0,
        FUNC_OFFER = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ADD,
        F_MIX,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_INIT,
        B_IDLE,
        B_PROBE,
        B_CLEAR
    } back_state_t;

    typedef struct packed {
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [COORD_W-1:0]  center_z;
        logic [WEIGHT_W-1:0] weight;
        logic [ZOOM_W-1:0]   zoom;
        logic [LIMIT_W-1:0]  abort_limit;
    } cfg_t;

    typedef struct packed {
        func_t               func;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [PRIO_W-1:0]   prio;
    } qitem_t;

    localparam int QITEM_W = $bits(qitem_t);

    typedef struct packed {
        status_t             status;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [ZOOM_W-1:0]   zoom;
        logic [PRIO_W-1:0]   prio;
        logic [IDX_W-1:0]    idx;
    } result_t;

endpackage

### rtl/bdpe_ram.sv
// ----------------------------------------------------------------------------
// bdpe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bdpe_fifo.sv
// ----------------------------------------------------------------------------
// bdpe_fifo
// Short register FIFO between the hash front end and the probe back end.
// ----------------------------------------------------------------------------
module bdpe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2    // power of two, at least 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/bdpe_front.sv
// ----------------------------------------------------------------------------
// bdpe_front
// Accepts transactions, computes the priority and the splitmix64 home slot
// with one shared 32x32 multiplier, and queues the classified item.
// ----------------------------------------------------------------------------
module bdpe_front
    import bdpe_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  logic               in_valid,
    output logic               in_ready,
    input  func_t              in_func,
    input  logic [COORD_W-1:0] in_x,
    input  logic [COORD_W-1:0] in_y,
    input  logic [COORD_W-1:0] in_z,
    input  cfg_t               cfg,
    output logic               push,
    input  logic               q_full,
    output qitem_t             push_item,
    output logic [SLOT_W-1:0]  push_slot
);

    // partial product order of one 64x64 (low half) multiply
    localparam logic [1:0] MUL_LO   = 2'd0;
    localparam logic [1:0] MUL_HI_A = 2'd1;
    localparam logic [1:0] MUL_HI_B = 2'd2;

    function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    front_state_t      state_reg, state_next;
    qitem_t            item_reg, item_next;
    logic [63:0]       val_reg, val_next;
    logic [63:0]       op_reg, op_next;
    logic [63:0]       acc_reg, acc_next;
    logic              pass_reg, pass_next;
    logic [1:0]        step_reg, step_next;
    logic [DIST_W-1:0] dist_reg, dist_next;

    logic [63:0] mul_const;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] addend;
    logic [63:0] hash;

    assign mul_const = pass_reg ? HASH_MUL2 : HASH_MUL1;
    assign mul_a     = (step_reg == MUL_HI_A) ? op_reg[63:32] : op_reg[31:0];
    assign mul_b     = (step_reg == MUL_HI_B) ? mul_const[63:32] : mul_const[31:0];
    assign prod      = mul_a * mul_b;
    assign addend    = (step_reg == MUL_LO) ? prod : {prod[31:0], 32'd0};
    assign hash      = acc_reg ^ (acc_reg >> HASH_SH3);

    assign push_item = item_reg;
    assign push_slot = hash[SLOT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        val_next   = val_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        pass_next  = pass_reg;
        step_next  = step_reg;
        dist_next  = dist_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = enable;
                if (in_valid && enable)
                begin
                    item_next.func = in_func;
                    item_next.x    = in_x;
                    item_next.y    = in_y;
                    item_next.z    = in_z;
                    item_next.prio = '0;
                    state_next     = (in_func == FUNC_OFFER) ? F_ADD : F_PUSH;
                end
            end
            F_ADD:
            begin
                val_next  = {16'd0, item_reg.x, item_reg.y, item_reg.z} + HASH_INC;
                dist_next = DIST_W'(absdiff(item_reg.x, cfg.center_x))
                          + DIST_W'(absdiff(item_reg.y, cfg.center_y))
                          + DIST_W'(absdiff(item_reg.z, cfg.center_z));
                pass_next  = 1'b0;
                state_next = F_MIX;
            end
            F_MIX:
            begin
                op_next   = pass_reg ? (acc_reg ^ (acc_reg >> HASH_SH2))
                                     : (val_reg ^ (val_reg >> HASH_SH1));
                acc_next  = '0;
                step_next = MUL_LO;
                if (!pass_reg)
                begin
                    item_next.prio = PRIO_W'(dist_reg)
                                   + {{(PRIO_W-WEIGHT_W){cfg.weight[WEIGHT_W-1]}}, cfg.weight};
                end
                state_next = F_MUL;
            end
            F_MUL:
            begin
                acc_next  = acc_reg + addend;
                step_next = step_reg + 2'd1;
                if (step_reg == MUL_HI_B)
                begin
                    if (pass_reg)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        state_next = F_MIX;
                    end
                end
            end
            F_PUSH:
            begin
                push = !q_full;
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pass_reg  <= 1'b0;
            step_reg  <= MUL_LO;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        val_reg  <= val_next;
        op_reg   <= op_next;
        acc_reg  <= acc_next;
        dist_reg <= dist_next;
    end

endmodule

### rtl/bdpe_back.sv
// ----------------------------------------------------------------------------
// bdpe_back
// Linear-probe engine over the slot table, result register, accepted count
// and the table clearing sweep.
// ----------------------------------------------------------------------------
module bdpe_back
    import bdpe_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int MAX_RESULTS = MAX_RESULTS_DEF,
    localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
    input  logic              clk,
    input  logic              rst_n,
    output logic              init_done,
    input  logic              q_valid,
    output logic              q_pop,
    input  qitem_t            q_item,
    input  logic [SLOT_W-1:0] q_slot,
    input  cfg_t              cfg,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    back_state_t       state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] probe_reg, probe_next;
    logic [SLOT_W-1:0] sweep_reg, sweep_next;
    qitem_t            item_reg, item_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;

    logic               ram_we, ram_re;
    logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic               res_load;
    logic               out_free;
    logic               out_full;
    logic               limit_hit;
    logic [CNT_W-1:0]   count_inc;
    logic [KEY_W-1:0]   item_key;
    logic               entry_valid;
    logic [KEY_W-1:0]   entry_key;

    bdpe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item_key    = {item_reg.x, item_reg.y, item_reg.z};
    assign entry_valid = ram_rdata[KEY_W];
    assign entry_key   = ram_rdata[KEY_W-1:0];
    assign out_free    = !res_valid_reg || res_ready;
    assign count_inc   = count_reg + 1'b1;
    assign out_full    = (count_reg >= CNT_W'(MAX_RESULTS));
    // negative limit disables the stop report
    assign limit_hit   = !cfg.abort_limit[LIMIT_W-1]
                      && (32'(count_inc) > 32'(cfg.abort_limit[LIMIT_W-2:0]));

    assign init_done = (state_reg != B_INIT);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        probe_next = probe_reg;
        sweep_next = sweep_reg;
        item_next  = item_reg;
        count_next = count_reg;
        res_next   = res_reg;
        res_load   = 1'b0;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = sweep_reg;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = slot_reg;
        unique case (state_reg)
            B_INIT:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.func == FUNC_CLEAR)
                    begin
                        sweep_next = '0;
                        state_next = B_CLEAR;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = q_slot;
                        slot_next  = q_slot;
                        probe_next = '0;
                        state_next = B_PROBE;
                    end
                end
            end
            B_PROBE:
            begin
                if (!entry_valid)
                begin
                    // empty slot: insert, even when the result store is full
                    ram_we     = 1'b1;
                    ram_waddr  = slot_reg;
                    ram_wdata  = {1'b1, item_key};
                    res_load   = 1'b1;
                    res_next   = '0;
                    state_next = B_IDLE;
                    if (out_full)
                    begin
                        res_next.status = ST_OUT_FULL;
                    end
                    else
                    begin
                        res_next.status = limit_hit ? ST_ACCEPT_STOP : ST_ACCEPTED;
                        res_next.x      = item_reg.x;
                        res_next.y      = item_reg.y;
                        res_next.z      = item_reg.z;
                        res_next.zoom   = cfg.zoom;
                        res_next.prio   = item_reg.prio;
                        res_next.idx    = IDX_W'(count_reg);
                        count_next      = count_inc;
                    end
                end
                else if (entry_key == item_key)
                begin
                    res_load        = 1'b1;
                    res_next        = '0;
                    res_next.status = ST_DUPLICATE;
                    state_next      = B_IDLE;
                end
                else if (probe_reg == '1)
                begin
                    res_load        = 1'b1;
                    res_next        = '0;
                    res_next.status = ST_TABLE_FULL;
                    state_next      = B_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot_reg + 1'b1;
                    slot_next  = slot_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                end
            end
            B_CLEAR:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1)
                begin
                    count_next      = '0;
                    res_load        = 1'b1;
                    res_next        = '0;
                    res_next.status = ST_CLEARED;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        res_valid_next = res_load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            sweep_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        probe_reg <= probe_next;
        item_reg  <= item_next;
        res_reg   <= res_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RESULTS))
        else $error("accepted count above result store size");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("slot table read and write in one cycle");

    a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_INIT) |-> !q_pop)
        else $error("queue popped during reset clearing pass");

    a_out_reg_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PROBE || state_reg == B_CLEAR) |-> !res_valid_reg)
        else $error("result register busy while an item is in work");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (res_next.status == ST_ACCEPTED || res_next.status == ST_ACCEPT_STOP))
        |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("accepted count did not advance on acceptance");
`endif

endmodule

### rtl/bucket_dedup_priority_emitter.sv
// ----------------------------------------------------------------------------
// bucket_dedup_priority_emitter
// Offer item: the hash front end runs add, mix, multiply, a second mix and
//   multiply on the shared 32x32 multiplier, then push; the back end reads the
//   home slot and one more slot per extra linear probe, then loads the result
//   register. The hash sequencer takes a new offer only after pushing the last
//   one; the back end overlaps through the 2-entry queue. A clear item sweeps
//   every slot. Reset: a clearing pass of the slot table runs first;
//   s_axis_tready stays low until it ends. Config regs take their reset values.
// ----------------------------------------------------------------------------
module bucket_dedup_priority_emitter
    import bdpe_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,  // power of two
    parameter int MAX_RESULTS = MAX_RESULTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // bucket_x, bucket_y, bucket_z
    input  logic                  s_axis_tuser,   // func
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // out_x, out_y, out_z, out_zoom,
                                                  // priority_res, result_index, pad
    output logic [2:0]            m_axis_tuser,   // status
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int Q_W    = QITEM_W + SLOT_W;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access-phase edge; the
    // word address is paddr[4:2], unused indexes are ignored.
    // ------------------------------------------------------------------
    cfg_t     cfg_reg, cfg_next;
    logic     cfg_we;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_CENTER_X:    cfg_next.center_x    = pwdata[COORD_W-1:0];
                REG_CENTER_Y:    cfg_next.center_y    = pwdata[COORD_W-1:0];
                REG_CENTER_Z:    cfg_next.center_z    = pwdata[COORD_W-1:0];
                REG_WEIGHT:      cfg_next.weight      = pwdata[WEIGHT_W-1:0];
                REG_ZOOM:        cfg_next.zoom        = pwdata[ZOOM_W-1:0];
                REG_ABORT_LIMIT: cfg_next.abort_limit = pwdata[LIMIT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Signed registers read back sign-extended.
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_CENTER_X:    prdata = CFG_DATA_W'(cfg_reg.center_x);
            REG_CENTER_Y:    prdata = CFG_DATA_W'(cfg_reg.center_y);
            REG_CENTER_Z:    prdata = CFG_DATA_W'(cfg_reg.center_z);
            REG_WEIGHT:      prdata = {{(CFG_DATA_W-WEIGHT_W){cfg_reg.weight[WEIGHT_W-1]}},
                                       cfg_reg.weight};
            REG_ZOOM:        prdata = CFG_DATA_W'(cfg_reg.zoom);
            REG_ABORT_LIMIT: prdata = {{(CFG_DATA_W-LIMIT_W){cfg_reg.abort_limit[LIMIT_W-1]}},
                                       cfg_reg.abort_limit};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
            cfg_reg.center_z    <= '0;
            cfg_reg.weight      <= '0;
            cfg_reg.zoom        <= '0;
            cfg_reg.abort_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Front end: takes the transaction, hashes the key, computes priority.
    // ------------------------------------------------------------------
    logic              init_done;
    logic              f_push;
    logic              q_full;
    qitem_t            f_item;
    logic [SLOT_W-1:0] f_slot;

    bdpe_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (init_done),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (func_t'(s_axis_tuser)),
        .in_x      (s_axis_tdata[COORD_W-1:0]),
        .in_y      (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .in_z      (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .cfg       (cfg_reg),
        .push      (f_push),
        .q_full    (q_full),
        .push_item (f_item),
        .push_slot (f_slot)
    );

    // ------------------------------------------------------------------
    // Queue between hash and probe, so each side stalls on its own.
    // ------------------------------------------------------------------
    logic [Q_W-1:0]    q_wr_word, q_rd_word;
    logic              q_valid, q_pop;
    qitem_t            q_item;
    logic [SLOT_W-1:0] q_slot;

    assign q_wr_word = {f_slot, f_item};
    assign q_item    = qitem_t'(q_rd_word[QITEM_W-1:0]);
    assign q_slot    = q_rd_word[Q_W-1:QITEM_W];

    bdpe_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .wr_data   (q_wr_word),
        .full      (q_full),
        .pop       (q_pop),
        .rd_data   (q_rd_word),
        .not_empty (q_valid)
    );

    // ------------------------------------------------------------------
    // Back end: probes the slot table and holds the result transaction.
    // ------------------------------------------------------------------
    result_t res;

    bdpe_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_RESULTS (MAX_RESULTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_done (init_done),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .q_slot    (q_slot),
        .cfg       (cfg_reg),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {3'd0, res.idx, res.prio, res.zoom, res.z, res.y, res.x};

endmodule
